FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is high.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication checked at every rising edge, ignored in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every rising edge, ignored in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tbrs_pkg.sv
// Types, codes and reset constants of the throttle and brake ramp sequencer.
// No dependencies; imported by tbrs_step and the top level.
package tbrs_pkg;

   localparam int unsigned LevelW  = 8;
   localparam int unsigned PeriodW = 10;
   localparam int unsigned CountW  = 16;
   localparam int unsigned ActionW = 2;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 10;

   typedef logic [LevelW-1:0]  level_type;
   typedef logic [PeriodW-1:0] period_type;
   typedef logic [CountW-1:0]  count_type;
   typedef logic [ActionW-1:0] action_type;
   typedef logic [CsrIdxW-1:0] csr_index_type;
   typedef logic [CsrDataW-1:0] csr_data_type;

   // Request action codes.
   localparam action_type ACT_TICK    = 2'd0;
   localparam action_type ACT_COMMAND = 2'd1;
   localparam action_type ACT_PEDAL   = 2'd2;
   localparam action_type ACT_NONE    = 2'd3;

   // Register indexes.
   localparam csr_index_type CSR_LOW_LIMIT     = 3'd0;
   localparam csr_index_type CSR_HIGH_LIMIT    = 3'd1;
   localparam csr_index_type CSR_THR_UP_PERIOD = 3'd2;
   localparam csr_index_type CSR_THR_DN_PERIOD = 3'd3;
   localparam csr_index_type CSR_BRK_UP_PERIOD = 3'd4;

   // Reset values.
   localparam level_type  RST_LOW_LIMIT     = 8'd25;
   localparam level_type  RST_HIGH_LIMIT    = 8'd225;
   localparam period_type RST_THR_UP_PERIOD = 10'd10;
   localparam period_type RST_THR_DN_PERIOD = 10'd5;
   localparam period_type RST_BRK_UP_PERIOD = 10'd15;
   localparam count_type  COUNT_MAX         = 16'hFFFF;

   typedef struct packed {
      level_type  low_limit;
      level_type  high_limit;
      period_type thr_up_period;
      period_type thr_dn_period;
      period_type brk_up_period;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic       automated_mode;
      logic       clear_emergency;
      level_type  throttle_goal;
      logic       throttle_switch_goal;
      level_type  brake_goal;
      logic       brake_switch_goal;
   } req_type;

   typedef struct packed {
      level_type throttle_now;
      level_type brake_now;
      logic      thr_sw_now;
      logic      brk_sw_now;
      level_type thr_target;
      level_type brk_target;
      logic      thr_sw_target;
      logic      brk_sw_target;
      logic      mode_auto;
      logic      emergency;
      count_type ms_count;
   } state_type;

   // Clamp into the drive window; the high limit wins if the limits cross.
   function automatic level_type clamp_level(level_type v, level_type low, level_type high);
      level_type r;
      r = (v < low) ? low : v;
      r = (r > high) ? high : r;
      return r;
   endfunction

endpackage

FILE: rtl/core/tbrs_step.sv
// Next-state logic of the sequencer for one request.
// Depends on tbrs_pkg.
module tbrs_step (
   input  tbrs_pkg::cfg_type   cfg,
   input  tbrs_pkg::req_type   req,
   input  tbrs_pkg::state_type st,
   output tbrs_pkg::state_type nx
);
   import tbrs_pkg::*;

   count_type cnt_inc;
   logic      thr_dn_due;
   logic      thr_up_due;
   logic      brk_up_due;

   assign cnt_inc    = (st.ms_count == COUNT_MAX) ? st.ms_count : st.ms_count + 1'b1;
   assign thr_dn_due = cnt_inc > CountW'(cfg.thr_dn_period);
   assign thr_up_due = cnt_inc > CountW'(cfg.thr_up_period);
   assign brk_up_due = cnt_inc > CountW'(cfg.brk_up_period);

   always_comb begin
      nx = st;
      case (req.action)
         ACT_TICK: begin
            nx.ms_count = cnt_inc;
            if (st.thr_sw_now) begin
               if (st.throttle_now > st.thr_target) begin
                  if (thr_dn_due) begin
                     nx.throttle_now = st.throttle_now - 1'b1;
                     nx.ms_count     = '0;
                  end
               end else if (st.throttle_now < st.thr_target) begin
                  if (thr_up_due) begin
                     nx.throttle_now = st.throttle_now + 1'b1;
                     nx.ms_count     = '0;
                  end
               end else if (st.thr_sw_now != st.thr_sw_target) begin
                  nx.thr_sw_now = ~st.thr_sw_now;
               end
            end else if (!st.brk_sw_now) begin
               // The brake releases at once but ramps up.
               if (st.brake_now > st.brk_target) begin
                  nx.brake_now = st.brk_target;
               end else if (st.brake_now < st.brk_target) begin
                  if (brk_up_due) begin
                     nx.brake_now = st.brake_now + 1'b1;
                     nx.ms_count  = '0;
                  end
               end else if (st.brk_sw_now != st.brk_sw_target) begin
                  nx.brk_sw_now = ~st.brk_sw_now;
               end
            end else begin
               if (st.brk_sw_now != st.brk_sw_target) begin
                  nx.brk_sw_now = ~st.brk_sw_now;
               end else if (st.thr_sw_now != st.thr_sw_target) begin
                  nx.thr_sw_now = ~st.thr_sw_now;
               end
            end
         end
         ACT_COMMAND: begin
            nx.mode_auto     = req.automated_mode;
            nx.emergency     = st.emergency & ~req.clear_emergency;
            nx.thr_target    = clamp_level(req.throttle_goal, cfg.low_limit, cfg.high_limit);
            nx.brk_target    = clamp_level(req.brake_goal, cfg.low_limit, cfg.high_limit);
            nx.thr_sw_target = req.throttle_switch_goal;
            nx.brk_sw_target = req.brake_switch_goal;
            nx.throttle_now  = clamp_level(st.throttle_now, cfg.low_limit, cfg.high_limit);
            nx.brake_now     = clamp_level(st.brake_now, cfg.low_limit, cfg.high_limit);
         end
         ACT_PEDAL: begin
            nx.emergency = st.emergency | st.mode_auto;
         end
         default: begin
            nx = st;
         end
      endcase

      // A latched emergency pins full brake, minimum throttle, switches off.
      if (req.action != ACT_NONE && nx.emergency) begin
         nx.throttle_now  = cfg.low_limit;
         nx.brake_now     = cfg.high_limit;
         nx.thr_target    = cfg.low_limit;
         nx.brk_target    = cfg.high_limit;
         nx.thr_sw_now    = 1'b0;
         nx.brk_sw_now    = 1'b0;
         nx.thr_sw_target = 1'b0;
         nx.brk_sw_target = 1'b0;
      end
   end

endmodule

FILE: rtl/core/throttle_brake_ramp_sequencer.sv
// Top level of the throttle and brake ramp sequencer.
// Depends on tbrs_pkg, tbrs_step and assert_macros.svh.
//
//   Channel   Direction  Handshake            Content
//   req_*     in         req_valid/req_ready  tick, command or brake pedal request
//   rsp_*     out        rsp_valid/rsp_ready  drive levels, switches, relay, emergency
//   csr_*     in         csr_wr_en            limits and ramp periods, no read-back
//
// A request is captured in the input register and applied once the output stage
// is free, which makes its response valid. One request per cycle is sustained
// while responses are taken; the combinational tbrs_step logic sets that rate.
// Reset is synchronous and active high and restores all limits and state.
// A stalled response holds the state update of the request behind it in the
// input register; req_ready drops only when both stages are full.
`include "assert_macros.svh"

module throttle_brake_ramp_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tbrs_pkg::action_type    req_action,
   input  logic                    req_automated_mode,
   input  logic                    req_clear_emergency,
   input  tbrs_pkg::level_type     req_throttle_goal,
   input  logic                    req_throttle_switch_goal,
   input  tbrs_pkg::level_type     req_brake_goal,
   input  logic                    req_brake_switch_goal,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tbrs_pkg::level_type     rsp_throttle_drive,
   output tbrs_pkg::level_type     rsp_brake_drive,
   output logic                    rsp_throttle_switch_out,
   output logic                    rsp_brake_switch_out,
   output logic                    rsp_relay_on,
   output logic                    rsp_emergency_active,
   input  logic                    csr_wr_en,
   input  tbrs_pkg::csr_index_type csr_index,
   input  tbrs_pkg::csr_data_type  csr_wdata
);
   import tbrs_pkg::*;

   cfg_type   cfg_ff;
   req_type   req_ff;
   logic      in_valid_ff;
   logic      rsp_valid_ff;
   state_type st_ff;
   state_type st_in;
   logic      out_free;
   logic      in_free;
   logic      fire;

   // The output stage frees up when it is empty or its response is taken;
   // the input stage frees up when it is empty or moves on in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || out_free;
   assign req_ready = in_free;

   // Configuration registers. Writes to indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit     <= RST_LOW_LIMIT;
         cfg_ff.high_limit    <= RST_HIGH_LIMIT;
         cfg_ff.thr_up_period <= RST_THR_UP_PERIOD;
         cfg_ff.thr_dn_period <= RST_THR_DN_PERIOD;
         cfg_ff.brk_up_period <= RST_BRK_UP_PERIOD;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_LIMIT:     cfg_ff.low_limit     <= csr_wdata[LevelW-1:0];
            CSR_HIGH_LIMIT:    cfg_ff.high_limit    <= csr_wdata[LevelW-1:0];
            CSR_THR_UP_PERIOD: cfg_ff.thr_up_period <= csr_wdata[PeriodW-1:0];
            CSR_THR_DN_PERIOD: cfg_ff.thr_dn_period <= csr_wdata[PeriodW-1:0];
            CSR_BRK_UP_PERIOD: cfg_ff.brk_up_period <= csr_wdata[PeriodW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         req_ff.action               <= req_action;
         req_ff.automated_mode       <= req_automated_mode;
         req_ff.clear_emergency      <= req_clear_emergency;
         req_ff.throttle_goal        <= req_throttle_goal;
         req_ff.throttle_switch_goal <= req_throttle_switch_goal;
         req_ff.brake_goal           <= req_brake_goal;
         req_ff.brake_switch_goal    <= req_brake_switch_goal;
      end
   end

   tbrs_step u_step (
      .cfg (cfg_ff),
      .req (req_ff),
      .st  (st_ff),
      .nx  (st_in)
   );

   // The state registers double as the response register: the state advances
   // only when no response is pending or the pending one is being taken, so
   // the response fields always show the state left by the request being answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.throttle_now  <= RST_LOW_LIMIT;
         st_ff.brake_now     <= RST_HIGH_LIMIT;
         st_ff.thr_sw_now    <= 1'b0;
         st_ff.brk_sw_now    <= 1'b0;
         st_ff.thr_target    <= RST_LOW_LIMIT;
         st_ff.brk_target    <= RST_HIGH_LIMIT;
         st_ff.thr_sw_target <= 1'b0;
         st_ff.brk_sw_target <= 1'b0;
         st_ff.mode_auto     <= 1'b0;
         st_ff.emergency     <= 1'b0;
         st_ff.ms_count      <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_throttle_drive      = st_ff.throttle_now;
   assign rsp_brake_drive         = st_ff.brake_now;
   assign rsp_throttle_switch_out = st_ff.thr_sw_now;
   assign rsp_brake_switch_out    = st_ff.brk_sw_now;
   assign rsp_relay_on            = st_ff.mode_auto;
   assign rsp_emergency_active    = st_ff.emergency;

   `ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff, "applied request produced no response")
   `ASSERT_NEXT(a_held_request_kept, clock, reset, in_valid_ff && !out_free, in_valid_ff && $stable(req_ff), "stalled request lost from input register")
   `ASSERT_IMPLY(a_emergency_switches_off, clock, reset, rsp_valid_ff && st_ff.emergency, !st_ff.thr_sw_now && !st_ff.brk_sw_now, "switch on during emergency")
   `ASSERT_IMPLY(a_emergency_needs_auto, clock, reset, $rose(st_ff.emergency), $past(st_ff.mode_auto), "emergency latched in manual mode")

endmodule

FILE: dv/throttle_brake_ramp_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for throttle_brake_ramp_sequencer: directed and random
// tick, command and pedal requests, with each response checked against a predictor.
// Depends on tbrs_pkg and the RTL top level; needs no files or arguments.

module throttle_brake_ramp_sequencer_tb;
   import tbrs_pkg::*;

   localparam int unsigned ClockPeriod    = 8;
   localparam int unsigned ResetCycles    = 11;
   // Generous limit for the slowest correct run.
   localparam int unsigned CycleLimit     = 1_000_000;
   // Margin waited after the last response, before register writes and at the end.
   localparam int unsigned DrainCycles    = 8;
   localparam int unsigned HoldOffCycles  = 300;
   localparam int unsigned HoldOffAfter   = 120;
   localparam int unsigned RandomPerPhase = 205;

   // One response as the block presents it.
   typedef struct packed {
      level_type throttle_drive;
      level_type brake_drive;
      logic      throttle_switch_out;
      logic      brake_switch_out;
      logic      relay_on;
      logic      emergency_active;
   } drive_status_type;

   // Tracks the sequencer state from the accepted requests and keeps the queue
   // of drive states that the responses must show, oldest first.
   class drive_tracker;
      cfg_type          cfg;
      level_type        throttle_now, brake_now, throttle_target, brake_target;
      logic             thr_sw_now, brk_sw_now, thr_sw_target, brk_sw_target;
      logic             mode_auto, emergency;
      count_type        ms_count;
      drive_status_type expected_status[$];
      int unsigned      mismatches, requests_noted, responses_checked;
      int unsigned      emergencies_latched, ramp_steps;

      function new();
         cfg.low_limit     = RST_LOW_LIMIT;
         cfg.high_limit    = RST_HIGH_LIMIT;
         cfg.thr_up_period = RST_THR_UP_PERIOD;
         cfg.thr_dn_period = RST_THR_DN_PERIOD;
         cfg.brk_up_period = RST_BRK_UP_PERIOD;
         throttle_now    = RST_LOW_LIMIT;
         brake_now       = RST_HIGH_LIMIT;
         throttle_target = RST_LOW_LIMIT;
         brake_target    = RST_HIGH_LIMIT;
         thr_sw_now      = 1'b0;
         brk_sw_now      = 1'b0;
         thr_sw_target   = 1'b0;
         brk_sw_target   = 1'b0;
         mode_auto       = 1'b0;
         emergency       = 1'b0;
         ms_count        = '0;
      endfunction

      function void write_register(csr_index_type idx, csr_data_type data);
         case (idx)
            CSR_LOW_LIMIT:     cfg.low_limit     = data[LevelW-1:0];
            CSR_HIGH_LIMIT:    cfg.high_limit    = data[LevelW-1:0];
            CSR_THR_UP_PERIOD: cfg.thr_up_period = data;
            CSR_THR_DN_PERIOD: cfg.thr_dn_period = data;
            CSR_BRK_UP_PERIOD: cfg.brk_up_period = data;
            default: ;
         endcase
      endfunction

      // Low limit first, then high limit, so crossed limits give the high one.
      function level_type limit_level(level_type v);
         level_type r;
         r = (v < cfg.low_limit) ? cfg.low_limit : v;
         if (r > cfg.high_limit) r = cfg.high_limit;
         return r;
      endfunction

      // True when the shared counter is past the period; a step clears it.
      function logic period_elapsed(period_type period);
         if (ms_count > count_type'(period)) begin
            ms_count = '0;
            ramp_steps++;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void advance_one_ms();
         if (ms_count != COUNT_MAX) ms_count++;
         if (thr_sw_now) begin
            if (throttle_now > throttle_target) begin
               if (period_elapsed(cfg.thr_dn_period)) throttle_now = throttle_now - 1'b1;
            end else if (throttle_now < throttle_target) begin
               if (period_elapsed(cfg.thr_up_period)) throttle_now = throttle_now + 1'b1;
            end else if (thr_sw_now != thr_sw_target) begin
               thr_sw_now = ~thr_sw_now;
            end
         end else if (!brk_sw_now) begin
            if (brake_now > brake_target) begin
               brake_now = brake_target;
            end else if (brake_now < brake_target) begin
               if (period_elapsed(cfg.brk_up_period)) brake_now = brake_now + 1'b1;
            end else if (brk_sw_now != brk_sw_target) begin
               brk_sw_now = ~brk_sw_now;
            end
         end else begin
            if (brk_sw_now != brk_sw_target) brk_sw_now = ~brk_sw_now;
            else if (thr_sw_now != thr_sw_target) thr_sw_now = ~thr_sw_now;
         end
      endfunction

      function void note_request(req_type r);
         drive_status_type status;
         requests_noted++;
         case (r.action)
            ACT_TICK: advance_one_ms();
            ACT_COMMAND: begin
               mode_auto = r.automated_mode;
               if (r.clear_emergency) emergency = 1'b0;
               throttle_target = limit_level(r.throttle_goal);
               thr_sw_target   = r.throttle_switch_goal;
               brake_target    = limit_level(r.brake_goal);
               brk_sw_target   = r.brake_switch_goal;
               throttle_now    = limit_level(throttle_now);
               brake_now       = limit_level(brake_now);
            end
            ACT_PEDAL: begin
               if (mode_auto) begin
                  if (!emergency) emergencies_latched++;
                  emergency = 1'b1;
               end
            end
            default: ;
         endcase
         if (r.action != ACT_NONE && emergency) begin
            throttle_now    = cfg.low_limit;
            throttle_target = cfg.low_limit;
            brake_now       = cfg.high_limit;
            brake_target    = cfg.high_limit;
            thr_sw_now      = 1'b0;
            brk_sw_now      = 1'b0;
            thr_sw_target   = 1'b0;
            brk_sw_target   = 1'b0;
         end
         status.throttle_drive      = throttle_now;
         status.brake_drive         = brake_now;
         status.throttle_switch_out = thr_sw_now;
         status.brake_switch_out    = brk_sw_now;
         status.relay_on            = mode_auto;
         status.emergency_active    = emergency;
         expected_status.push_back(status);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_response(drive_status_type got);
         drive_status_type want;
         responses_checked++;
         if (expected_status.size() == 0) begin
            mismatches++;
            $error("response with no request outstanding");
            return;
         end
         want = expected_status.pop_front();
         compare_field("throttle_drive", want.throttle_drive, got.throttle_drive);
         compare_field("brake_drive", want.brake_drive, got.brake_drive);
         compare_field("throttle_switch_out", want.throttle_switch_out,
                       got.throttle_switch_out);
         compare_field("brake_switch_out", want.brake_switch_out, got.brake_switch_out);
         compare_field("relay_on", want.relay_on, got.relay_on);
         compare_field("emergency_active", want.emergency_active, got.emergency_active);
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   action_type    req_action = ACT_TICK;
   logic          req_automated_mode = 1'b0;
   logic          req_clear_emergency = 1'b0;
   level_type     req_throttle_goal = '0;
   logic          req_throttle_switch_goal = 1'b0;
   level_type     req_brake_goal = '0;
   logic          req_brake_switch_goal = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   level_type     rsp_throttle_drive;
   level_type     rsp_brake_drive;
   logic          rsp_throttle_switch_out;
   logic          rsp_brake_switch_out;
   logic          rsp_relay_on;
   logic          rsp_emergency_active;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   drive_tracker  tracker = new();

   // Percent of cycles in which each side idles; changed between phases.
   int unsigned   sender_idle_pct = 9;
   int unsigned   receiver_idle_pct = 88;
   int unsigned   hold_left = 0;
   int unsigned   cycle_count = 0;
   int unsigned   settings_used = 1;

   throttle_brake_ramp_sequencer DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_action               (req_action),
      .req_automated_mode       (req_automated_mode),
      .req_clear_emergency      (req_clear_emergency),
      .req_throttle_goal        (req_throttle_goal),
      .req_throttle_switch_goal (req_throttle_switch_goal),
      .req_brake_goal           (req_brake_goal),
      .req_brake_switch_goal    (req_brake_switch_goal),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_throttle_drive       (rsp_throttle_drive),
      .rsp_brake_drive          (rsp_brake_drive),
      .rsp_throttle_switch_out  (rsp_throttle_switch_out),
      .rsp_brake_switch_out     (rsp_brake_switch_out),
      .rsp_relay_on             (rsp_relay_on),
      .rsp_emergency_active     (rsp_emergency_active),
      .csr_wr_en                (csr_wr_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("throttle_brake_ramp_sequencer test failed");
         $finish;
      end
   end

   // Response side. Outputs are sampled as they stood at the edge, then the
   // ready for the next cycle is chosen. Once, after a fixed number of
   // responses, ready is held low for a long stretch so that both pipeline
   // stages fill and req_ready has to drop while the sender keeps offering.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_response('{rsp_throttle_drive, rsp_brake_drive,
                                  rsp_throttle_switch_out, rsp_brake_switch_out,
                                  rsp_relay_on, rsp_emergency_active});
         if (tracker.responses_checked == HoldOffAfter) hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic req_type random_request();
      req_type r;
      r.action               = action_type'($urandom_range(3));
      r.automated_mode       = 1'($urandom_range(1));
      r.clear_emergency      = 1'($urandom_range(1));
      r.throttle_goal        = level_type'($urandom_range(255));
      r.throttle_switch_goal = 1'($urandom_range(1));
      r.brake_goal           = level_type'($urandom_range(255));
      r.brake_switch_goal    = 1'($urandom_range(1));
      return r;
   endfunction

   // Offers one request and returns at the edge where it was accepted. An idle
   // gap, when one is drawn, comes before the request; valid is then held with
   // a steady payload until ready is seen.
   task automatic offer_request(input req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid                <= 1'b1;
      req_action               <= r.action;
      req_automated_mode       <= r.automated_mode;
      req_clear_emergency      <= r.clear_emergency;
      req_throttle_goal        <= r.throttle_goal;
      req_throttle_switch_goal <= r.throttle_switch_goal;
      req_brake_goal           <= r.brake_goal;
      req_brake_switch_goal    <= r.brake_switch_goal;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(r);
   endtask

   // Ticks and pedal requests carry random data in the unused fields.
   task automatic send_action(input action_type a);
      req_type r;
      r = random_request();
      r.action = a;
      offer_request(r);
   endtask

   task automatic send_command(input logic automated, input logic clear,
                               input level_type thr_goal, input logic thr_sw,
                               input level_type brk_goal, input logic brk_sw);
      req_type r;
      r.action               = ACT_COMMAND;
      r.automated_mode       = automated;
      r.clear_emergency      = clear;
      r.throttle_goal        = thr_goal;
      r.throttle_switch_goal = thr_sw;
      r.brake_goal           = brk_goal;
      r.brake_switch_goal    = brk_sw;
      offer_request(r);
   endtask

   task automatic write_register(input csr_index_type idx, input csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   // Drops valid, waits until every response is back and the DrainCycles margin
   // has passed, then writes one register per cycle.
   task automatic write_settings(input level_type low, input level_type high,
                                 input period_type thr_up, input period_type thr_dn,
                                 input period_type brk_up);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      write_register(CSR_LOW_LIMIT, csr_data_type'(low));
      write_register(CSR_HIGH_LIMIT, csr_data_type'(high));
      write_register(CSR_THR_UP_PERIOD, thr_up);
      write_register(CSR_THR_DN_PERIOD, thr_dn);
      write_register(CSR_BRK_UP_PERIOD, brk_up);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Random traffic shaped as a command followed by a run of ticks, so the
   // ramps, the switch hand-over and the emergency latch are all reached.
   // Pedal presses, unused codes and stray commands are sprinkled into the
   // runs. Requests that the block ignores are not counted.
   task automatic run_random_traffic(input int unsigned quota);
      req_type     r;
      int unsigned counted;
      int unsigned run_len;
      int unsigned pick;
      counted = 0;
      while (counted < quota) begin
         r = random_request();
         r.action = ACT_COMMAND;
         r.automated_mode = ($urandom_range(3) != 0);
         // Half of these leading commands aim close to the present levels so that ramps
         // finish and the switches get to move.
         if ($urandom_range(1)) begin
            r.throttle_goal = level_type'(tracker.throttle_now + $urandom_range(12) - 6);
            r.brake_goal    = level_type'(tracker.brake_now + $urandom_range(12) - 6);
         end
         offer_request(r);
         counted++;
         run_len = $urandom_range(40);
         repeat (run_len) begin
            r = random_request();
            pick = $urandom_range(99);
            if (pick < 3) r.action = ACT_PEDAL;
            else if (pick < 6) r.action = ACT_NONE;
            else if (pick < 8) r.action = ACT_COMMAND;
            else r.action = ACT_TICK;
            if (r.action != ACT_NONE && (r.action != ACT_PEDAL || tracker.mode_auto))
               counted++;
            offer_request(r);
         end
      end
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings.
      send_action(ACT_TICK);                    // nothing to do at rest
      send_action(ACT_NONE);                    // unused code changes nothing
      send_action(ACT_PEDAL);                   // pedal in manual mode is ignored
      // Goals outside the window are clamped to both limits.
      send_command(1'b1, 1'b0, 8'd255, 1'b1, 8'd0, 1'b1);
      repeat (4) send_action(ACT_TICK);         // brake drops at once, switches follow
      send_action(ACT_PEDAL);                   // pedal in automated mode latches
      send_action(ACT_TICK);
      // Without the clear bit the latch holds and the targets are overridden.
      send_command(1'b1, 1'b0, 8'd100, 1'b1, 8'd100, 1'b1);
      send_command(1'b0, 1'b1, 8'd0, 1'b0, 8'd255, 1'b0);
      send_action(ACT_PEDAL);
      send_action(ACT_NONE);
      send_command(1'b1, 1'b1, 8'd26, 1'b1, 8'd225, 1'b1);
      repeat (6) send_action(ACT_TICK);

      // Full window and zero periods: a step on every tick.
      write_settings(8'd0, 8'd255, 10'd0, 10'd0, 10'd0);
      run_random_traffic(RandomPerPhase);
      // Crossed limits: the high limit wins in every clamp.
      write_settings(8'd200, 8'd50, 10'd3, 10'd1, 10'd2);
      run_random_traffic(RandomPerPhase);

      sender_idle_pct   = 88;
      receiver_idle_pct = 9;
      write_settings(8'd90, 8'd160, 10'd1, 10'd0, 10'd4);
      run_random_traffic(RandomPerPhase);
      // Largest periods and a one-level window.
      write_settings(8'd255, 8'd255, 10'd1023, 10'd1023, 10'd1023);
      run_random_traffic(RandomPerPhase);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_settings(RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_THR_UP_PERIOD,
                     RST_THR_DN_PERIOD, RST_BRK_UP_PERIOD);
      run_random_traffic(RandomPerPhase);
      write_settings(8'd0, 8'd0, 10'd2, 10'd1, 10'd0);
      run_random_traffic(RandomPerPhase);
      write_settings(8'd40, 8'd210, 10'd2, 10'd3, 10'd1);
      run_random_traffic(RandomPerPhase);

      // Wait for the last responses, then a little longer for strays.
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_status.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d requests and %0d responses under %0d register settings.",
               tracker.requests_noted, tracker.responses_checked, settings_used);
      $display("Saw %0d ramp steps and %0d emergency latches; %0d mismatches.",
               tracker.ramp_steps, tracker.emergencies_latched, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.expected_status.size() == 0) begin
         $display("throttle_brake_ramp_sequencer test passed");
      end else begin
         $display("throttle_brake_ramp_sequencer test failed");
      end
      $finish;
   end

endmodule
